// ===== rtl/core/timing_wheel_scheduler_macros.svh =====
// assertion macros shared by the timing wheel checker
`ifndef TIMING_WHEEL_SCHEDULER_MACROS_SVH
`define TIMING_WHEEL_SCHEDULER_MACROS_SVH

// condition holds in the same cycle
`define TWS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("timing wheel check failed");

// condition holds in the following cycle
`define TWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("timing wheel check failed");

`endif

// ===== rtl/core/tws_pkg.sv =====
// types, sizes and codes of the timing wheel scheduler
`timescale 1ns / 1ps
package tws_pkg;

	localparam int NUM_SLOTS    = 16;
	localparam int SLOT_DEPTH   = 8;
	localparam int TASK_ID_BITS = 8;

	localparam int WAIT_W    = 20;
	localparam int PERIOD_W  = 16;
	localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int FILL_W    = $clog2(SLOT_DEPTH + 1);
	localparam int TADDR_W   = (NUM_SLOTS * SLOT_DEPTH > 1) ? $clog2(NUM_SLOTS * SLOT_DEPTH) : 1;
	localparam int DCNT_W    = $clog2(WAIT_W);
	localparam int PADDR_W   = 3;
	localparam int REG_IDX_W = PADDR_W - 2;
	localparam int PDATA_W   = 32;

	localparam logic [REG_IDX_W-1:0] REG_TICK_PERIOD   = '0;
	localparam logic [PERIOD_W-1:0]  TICK_PERIOD_RESET = PERIOD_W'(1000);

	localparam logic REQ_ADD        = 1'b0;
	localparam logic REQ_TICK       = 1'b1;
	localparam logic KIND_ACK       = 1'b0;
	localparam logic KIND_EXPIRED   = 1'b1;
	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_DROPPED = 1'b1;

	typedef struct packed {
		logic                    req_type;
		logic [WAIT_W-1:0]       wait_time;
		logic [TASK_ID_BITS-1:0] task_id;
	} req_word_t;

	typedef struct packed {
		logic                    result_kind;
		logic                    add_status;
		logic [TASK_ID_BITS-1:0] expired_task;
		logic                    last_of_run;
	} rsp_word_t;

	typedef struct packed {
		logic                start;
		logic [WAIT_W-1:0]   dividend;
		logic [PERIOD_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [SLOT_W-1:0] qmod;
	} div_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_FILL_RD,
		ST_FILL_CHK,
		ST_TICK_CHK,
		ST_DRAIN
	} state_t;

endpackage

// ===== rtl/core/timing_wheel_scheduler.sv =====
// timing wheel scheduler top level
// Requests enter on req (req_valid/req_ready), one word at a time; results leave on rsp
// (rsp_valid/rsp_ready). Configuration is the APB port; tick_period sits at address 0.
// An add word runs a divide of wait_time by tick_period, then reads the target
// slot's fill count from the fill ram and files the task in the task ram, unless the
// slot is full: its single acknowledgement then says dropped. A tick word reads the
// current slot's fill count and then streams the stored tasks from the task ram, last
// stored first, one per cycle while the output is free, marking the final one.
// One request is in flight at a time; req_ready rises again once its last result has
// been placed in the output register, so the next word is taken while that result waits.
// The divider sets the add time, the task ram read port sets the drain rate.
// When rsp_ready is low the output register holds its word and the sequencer waits.
// Reset empties every slot at once through per-slot valid bits, sets the current slot
// to zero and tick_period to 1000; no clearing pass is needed. A tick_period of zero
// divides as one.
`timescale 1ns / 1ps
module timing_wheel_scheduler (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  tws_pkg::req_word_t          req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output tws_pkg::rsp_word_t          rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tws_pkg::PADDR_W-1:0] paddr,
	input  logic [tws_pkg::PDATA_W-1:0] pwdata,
	output logic [tws_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);
	import tws_pkg::*;

	state_t                  state_q, state_d;
	logic [PERIOD_W-1:0]     tick_period_q;
	logic [SLOT_W-1:0]       cur_q;
	logic [SLOT_W-1:0]       target_q;
	logic [FILL_W-1:0]       cnt_q;
	logic [TASK_ID_BITS-1:0] task_q;
	logic [NUM_SLOTS-1:0]    slot_vld_q;
	logic                    rsp_valid_q;
	rsp_word_t               rsp_q;

	div_req_t                div_req;
	div_rsp_t                div_rsp;

	logic                    acc;
	logic                    out_free;
	logic                    out_load;
	rsp_word_t               out_next;

	logic                    fill_re;
	logic [SLOT_W-1:0]       fill_raddr;
	logic [FILL_W-1:0]       fill_rdata;
	logic                    fill_we;
	logic [FILL_W-1:0]       fill_wdata;
	logic                    task_re;
	logic [TADDR_W-1:0]      task_raddr;
	logic [TASK_ID_BITS-1:0] task_rdata;
	logic                    task_we;
	logic [TADDR_W-1:0]      task_waddr;

	logic [SLOT_W-1:0]       chk_slot;
	logic [FILL_W-1:0]       fill_raw;
	logic [FILL_W-1:0]       fill_val;
	logic                    slot_full;
	logic [SLOT_W:0]         tgt_sum;
	logic [SLOT_W-1:0]       tgt_next;
	logic [SLOT_W-1:0]       cur_next;
	logic [TADDR_W-1:0]      cur_base;
	logic [TADDR_W-1:0]      tgt_base;

	logic                    cnt_load;
	logic                    cnt_dec;
	logic                    vld_set;
	logic                    vld_clr;
	logic                    cur_adv;
	logic                    tgt_load;
	logic                    cfg_wr;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[PADDR_W-1:2] == REG_TICK_PERIOD);
	assign prdata = (paddr[PADDR_W-1:2] == REG_TICK_PERIOD)
		? PDATA_W'(tick_period_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_period_q <= TICK_PERIOD_RESET;
		end else if (cfg_wr) begin
			tick_period_q <= pwdata[PERIOD_W-1:0];
		end
	end

	// datapath helpers
	assign req_ready = (state_q == ST_IDLE);
	assign acc       = req_valid && req_ready;
	assign out_free  = !rsp_valid_q || rsp_ready;

	assign div_req.start    = acc && (req.req_type == REQ_ADD);
	assign div_req.dividend = req.wait_time;
	assign div_req.divisor  = (tick_period_q == '0) ? PERIOD_W'(1) : tick_period_q;

	tws_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		chk_slot  = (state_q == ST_FILL_CHK) ? target_q : cur_q;
		fill_raw  = slot_vld_q[chk_slot] ? fill_rdata : '0;
		fill_val  = (fill_raw > FILL_W'(SLOT_DEPTH)) ? FILL_W'(SLOT_DEPTH) : fill_raw;
		slot_full = (fill_val >= FILL_W'(SLOT_DEPTH));
		tgt_sum   = {1'b0, cur_q} + {1'b0, div_rsp.qmod};
		tgt_next  = (tgt_sum >= (SLOT_W+1)'(NUM_SLOTS))
			? SLOT_W'(tgt_sum - (SLOT_W+1)'(NUM_SLOTS)) : tgt_sum[SLOT_W-1:0];
		cur_next  = (cur_q == SLOT_W'(NUM_SLOTS - 1)) ? '0 : cur_q + 1'b1;
		cur_base  = TADDR_W'(cur_q) * TADDR_W'(SLOT_DEPTH);
		tgt_base  = TADDR_W'(target_q) * TADDR_W'(SLOT_DEPTH);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					state_d = (req.req_type == REQ_ADD) ? ST_DIV : ST_TICK_CHK;
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					state_d = ST_FILL_RD;
				end
			end
			ST_FILL_RD: begin
				state_d = ST_FILL_CHK;
			end
			ST_FILL_CHK: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_TICK_CHK: begin
				state_d = (fill_val == '0) ? ST_IDLE : ST_DRAIN;
			end
			ST_DRAIN: begin
				if (out_free && cnt_q == FILL_W'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		fill_re    = 1'b0;
		fill_raddr = cur_q;
		fill_we    = 1'b0;
		fill_wdata = fill_val + 1'b1;
		task_re    = 1'b0;
		task_raddr = cur_base + TADDR_W'(cnt_q) - TADDR_W'(2);
		task_we    = 1'b0;
		task_waddr = tgt_base + TADDR_W'(fill_val);
		out_load   = 1'b0;
		out_next   = '{KIND_ACK, STATUS_OK, '0, 1'b1};
		cnt_load   = 1'b0;
		cnt_dec    = 1'b0;
		vld_set    = 1'b0;
		vld_clr    = 1'b0;
		cur_adv    = 1'b0;
		tgt_load   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (acc && req.req_type == REQ_TICK) begin
					fill_re = 1'b1;
				end
			end
			ST_DIV: begin
				tgt_load = div_rsp.done;
			end
			ST_FILL_RD: begin
				fill_re    = 1'b1;
				fill_raddr = target_q;
			end
			ST_FILL_CHK: begin
				if (out_free) begin
					out_load = 1'b1;
					out_next = '{KIND_ACK, slot_full ? STATUS_DROPPED : STATUS_OK, '0, 1'b1};
					if (!slot_full) begin
						fill_we = 1'b1;
						task_we = 1'b1;
						vld_set = 1'b1;
					end
				end
			end
			ST_TICK_CHK: begin
				if (fill_val == '0) begin
					vld_clr = 1'b1;
					cur_adv = 1'b1;
				end else begin
					cnt_load   = 1'b1;
					task_re    = 1'b1;
					task_raddr = cur_base + TADDR_W'(fill_val) - TADDR_W'(1);
				end
			end
			ST_DRAIN: begin
				if (out_free) begin
					out_load = 1'b1;
					out_next = '{KIND_EXPIRED, STATUS_OK, task_rdata, cnt_q == FILL_W'(1)};
					cnt_dec  = 1'b1;
					if (cnt_q == FILL_W'(1)) begin
						vld_clr = 1'b1;
						cur_adv = 1'b1;
					end else begin
						task_re = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	tws_ram #(
		.WIDTH (FILL_W),
		.DEPTH (NUM_SLOTS)
	) u_fill_ram (
		.clk   (clk),
		.we    (fill_we),
		.waddr (target_q),
		.wdata (fill_wdata),
		.re    (fill_re),
		.raddr (fill_raddr),
		.rdata (fill_rdata)
	);

	tws_ram #(
		.WIDTH (TASK_ID_BITS),
		.DEPTH (NUM_SLOTS * SLOT_DEPTH)
	) u_task_ram (
		.clk   (clk),
		.we    (task_we),
		.waddr (task_waddr),
		.wdata (task_q),
		.re    (task_re),
		.raddr (task_raddr),
		.rdata (task_rdata)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_q       <= '0;
			cnt_q       <= '0;
			slot_vld_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cur_adv) begin
				cur_q <= cur_next;
			end
			if (cnt_load) begin
				cnt_q <= fill_val;
			end else if (cnt_dec) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (vld_set) begin
				slot_vld_q[target_q] <= 1'b1;
			end
			if (vld_clr) begin
				slot_vld_q[cur_q] <= 1'b0;
			end
			rsp_valid_q <= out_load || (rsp_valid_q && !rsp_ready);
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (acc) begin
			task_q <= req.task_id;
		end
		if (tgt_load) begin
			target_q <= tgt_next;
		end
		if (out_load) begin
			rsp_q <= out_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== rtl/core/tws_ram.sv =====
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module tws_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/tws_div.sv =====
// restoring divider, one quotient bit a cycle, quotient kept modulo the slot count
`timescale 1ns / 1ps
module tws_div (
	input  logic              clk,
	input  logic              arst_n,
	input  tws_pkg::div_req_t req,
	output tws_pkg::div_rsp_t rsp
);
	import tws_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [DCNT_W-1:0]   cnt_q;
	logic [WAIT_W-1:0]   dvd_q;
	logic [PERIOD_W-1:0] dsr_q;
	logic [PERIOD_W-1:0] rem_q;
	logic [SLOT_W-1:0]   qm_q;

	logic [PERIOD_W:0]   trial;
	logic                qbit;
	logic [PERIOD_W-1:0] rem_next;
	logic [SLOT_W:0]     qm_dbl;
	logic [SLOT_W-1:0]   qm_next;

	always_comb begin
		trial    = {rem_q, dvd_q[WAIT_W-1]};
		qbit     = (trial >= {1'b0, dsr_q});
		rem_next = qbit ? PERIOD_W'(trial - {1'b0, dsr_q}) : trial[PERIOD_W-1:0];
		qm_dbl   = {qm_q, qbit};
		qm_next  = (qm_dbl >= (SLOT_W+1)'(NUM_SLOTS))
			? SLOT_W'(qm_dbl - (SLOT_W+1)'(NUM_SLOTS)) : qm_dbl[SLOT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_W'(WAIT_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
			qm_q  <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[WAIT_W-2:0], 1'b0};
			rem_q <= rem_next;
			qm_q  <= qm_next;
		end
	end

	assign rsp.done = done_q;
	assign rsp.qmod = qm_q;

endmodule

// ===== rtl/core/tws_chk.sv =====
// port checker for the timing wheel scheduler, bound to the top level
`timescale 1ns / 1ps
`include "timing_wheel_scheduler_macros.svh"
module tws_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input tws_pkg::rsp_word_t rsp,
	input logic               psel,
	input logic               pready
);
	import tws_pkg::*;

	logic req_acc;
	logic rsp_stall;
	logic ack_seen;
	logic exp_seen;

	assign req_acc   = req_valid && req_ready;
	assign rsp_stall = rsp_valid && !rsp_ready;
	assign ack_seen  = rsp_valid && (rsp.result_kind == KIND_ACK);
	assign exp_seen  = rsp_valid && (rsp.result_kind == KIND_EXPIRED);

	`TWS_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_stall, rsp_valid && $stable(rsp))
	`TWS_ASSERT_NEXT(a_one_in_flight, clk, arst_n, req_acc, !req_ready)
	`TWS_ASSERT_NOW(a_ack_single, clk, arst_n, ack_seen, rsp.last_of_run && rsp.expired_task == '0)
	`TWS_ASSERT_NOW(a_exp_status, clk, arst_n, exp_seen, rsp.add_status == STATUS_OK)
	`TWS_ASSERT_NOW(a_pready_high, clk, arst_n, psel, pready)

endmodule

bind timing_wheel_scheduler tws_chk u_tws_chk (.*);
